// ===== rtl/core/mvp_pkg.sv =====
`default_nettype none
package mvp_pkg;

	// defaults for the top level parameters
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_WIDTH_DEF = 16;

	// fixed field widths
	localparam int VIDX_W = 10;
	localparam int POS_W = 16;
	localparam int THR_W = 15;
	localparam int VCNT_W = 11;
	localparam int CNT_W = 11;
	localparam int CFG_DATA_W = 16;

	// cycles from a position read to a registered distance
	localparam int SCAN_LAT = 4;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic {
		CFG_MID_THRESHOLD = 1'b0,
		CFG_VERTEX_COUNT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_I_RD,
		ST_I_CHK,
		ST_SCAN,
		ST_DRAIN,
		ST_WR_I,
		ST_J_RD,
		ST_J_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		action_t                  action;
		logic [VIDX_W-1:0]        vert_id;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} cmd_t;

	typedef struct packed {
		logic               is_mid;
		logic               right_partner_valid;
		logic [VIDX_W-1:0]  right_partner;
		logic               left_partner_valid;
		logic [VIDX_W-1:0]  left_partner;
		logic [CNT_W-1:0]   mid_count;
		logic [CNT_W-1:0]   left_count;
		logic [CNT_W-1:0]   right_count;
	} rsp_t;

	typedef struct packed {
		logic visited;
		logic mid;
		logic l2r_valid;
		logic r2l_valid;
	} tbl_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/mirror_vertex_pairing_core.sv =====
`default_nettype none
// a vertex write goes straight into the position store; a read passes the table read register
// and then the result register. a run first clears every entry of the pair table, then for
// each unvisited vertex that is not mid it does one position read per candidate, n of them with
// n = vertex_count, and drains the distance pipeline before the table update
// the single read port of the position store sets the scan rate of one candidate a cycle
// reset: control clears at once, then a clear of every table entry holds off items
module mirror_vertex_pairing_core #(
	parameter int MAX_VERTICES = mvp_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH = mvp_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_stall,
	input  wire mvp_pkg::cmd_t                   cmd,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output mvp_pkg::rsp_t                        rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire mvp_pkg::cfg_reg_t               cfg_index,
	input  wire logic [mvp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int NW = IW + 1;
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int SW = 2 * DW + 2;
	localparam int TW = (DW > mvp_pkg::THR_W) ? DW : mvp_pkg::THR_W;
	localparam int LW = $clog2(mvp_pkg::SCAN_LAT);
	localparam logic [IW-1:0] CLR_LAST = IW'(MAX_VERTICES - 1);
	localparam logic [LW-1:0] DRAIN_LAST = LW'(mvp_pkg::SCAN_LAT - 1);

	mvp_pkg::state_t state_q, state_d;

	// configuration
	logic [mvp_pkg::THR_W-1:0] mid_thr_q;
	logic [mvp_pkg::VCNT_W-1:0] vcnt_q;

	// sequencer
	logic [IW-1:0] clr_q;
	logic run_pend_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [LW-1:0] drain_q;
	logic rd_v_q;
	logic [IW-1:0] jr_q;
	logic rd_ok_q;

	// current vertex and best candidate
	logic signed [CW-1:0] xi_q, yi_q, zi_q;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [IW-1:0] best_j_q;

	// counts of the last run
	logic [NW-1:0] cnt_mid_q, cnt_l2r_q, cnt_r2l_q;

	logic rsp_valid_q;
	mvp_pkg::rsp_t rsp_q;

	// handshakes
	logic cmd_acc, rsp_free, in_range, is_mid_c, i_last, j_last, xi_neg;
	logic [IW-1:0] i_addr, vidx_addr;
	logic [DW-1:0] abs_xi;

	// store ports
	logic pos_we, pos_re;
	logic [IW-1:0] pos_raddr;
	logic signed [CW-1:0] pos_rx, pos_ry, pos_rz;
	logic tbl_we, tbl_re;
	logic [IW-1:0] tbl_waddr, tbl_raddr, tbl_wl2r, tbl_wr2l, tbl_rl2r, tbl_rr2l;
	mvp_pkg::tbl_flags_t tbl_wflags, tbl_rflags;

	// distance pipeline
	logic dist_v, dist_opp, take;
	logic [SW-1:0] dist_sq;
	logic [IW-1:0] dist_j;

	mvp_pos_store #(
		.DEPTH (MAX_VERTICES),
		.CW    (CW),
		.IW    (IW)
	) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (vidx_addr),
		.wx    (CW'(cmd.pos_x)),
		.wy    (CW'(cmd.pos_y)),
		.wz    (CW'(cmd.pos_z)),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rx    (pos_rx),
		.ry    (pos_ry),
		.rz    (pos_rz)
	);

	mvp_tbl_store #(
		.DEPTH (MAX_VERTICES),
		.IW    (IW)
	) u_tbl (
		.clk    (clk),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wflags (tbl_wflags),
		.wl2r   (tbl_wl2r),
		.wr2l   (tbl_wr2l),
		.re     (tbl_re),
		.raddr  (tbl_raddr),
		.rflags (tbl_rflags),
		.rl2r   (tbl_rl2r),
		.rr2l   (tbl_rr2l)
	);

	mvp_dist_pipe #(
		.CW (CW),
		.IW (IW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q),
		.xi        (xi_q),
		.yi        (yi_q),
		.zi        (zi_q),
		.xj        (pos_rx),
		.yj        (pos_ry),
		.zj        (pos_rz),
		.j_in      (jr_q),
		.out_valid (dist_v),
		.opposite  (dist_opp),
		.dist_sq   (dist_sq),
		.j_out     (dist_j)
	);

	// a write needs no result slot, so it goes in while a result waits
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != mvp_pkg::ST_IDLE) ||
		(rsp_valid_q && rsp_stall && cmd.action != mvp_pkg::ACT_WRITE);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign in_range = int'(cmd.vert_id) < MAX_VERTICES;
	assign vidx_addr = IW'(cmd.vert_id);
	assign i_addr = i_q[IW-1:0];
	assign i_last = (i_q == n_q);
	assign j_last = (NW'(j_q) == n_q - NW'(1));
	assign xi_neg = xi_q[CW-1];

	// mid test on the freshly read x of vertex i
	assign abs_xi = pos_rx[CW-1] ? DW'(-DW'(pos_rx)) : DW'(pos_rx);
	assign is_mid_c = TW'(abs_xi) < TW'(mid_thr_q);

	// first minimum wins: strict compare only
	assign take = dist_v && dist_opp && (!found_q || dist_sq < best_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mvp_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = run_pend_q ? mvp_pkg::ST_I_RD : mvp_pkg::ST_IDLE;
				end
			end
			mvp_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd.action)
						mvp_pkg::ACT_RUN:  state_d = mvp_pkg::ST_CLEAR;
						mvp_pkg::ACT_READ: state_d = mvp_pkg::ST_READ;
						default:           state_d = mvp_pkg::ST_IDLE;
					endcase
				end
			end
			mvp_pkg::ST_READ: state_d = mvp_pkg::ST_IDLE;
			mvp_pkg::ST_I_RD: state_d = i_last ? mvp_pkg::ST_DONE : mvp_pkg::ST_I_CHK;
			mvp_pkg::ST_I_CHK: begin
				if (tbl_rflags.visited || is_mid_c) begin
					state_d = mvp_pkg::ST_I_RD;
				end else begin
					state_d = mvp_pkg::ST_SCAN;
				end
			end
			mvp_pkg::ST_SCAN: begin
				if (j_last) begin
					state_d = mvp_pkg::ST_DRAIN;
				end
			end
			mvp_pkg::ST_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = mvp_pkg::ST_WR_I;
				end
			end
			mvp_pkg::ST_WR_I: state_d = found_q ? mvp_pkg::ST_J_RD : mvp_pkg::ST_I_RD;
			mvp_pkg::ST_J_RD: state_d = mvp_pkg::ST_J_WR;
			mvp_pkg::ST_J_WR: state_d = mvp_pkg::ST_I_RD;
			mvp_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = mvp_pkg::ST_IDLE;
				end
			end
			default: state_d = mvp_pkg::ST_IDLE;
		endcase
	end

	// store access per state
	always_comb begin
		pos_we = 1'b0;
		pos_re = 1'b0;
		pos_raddr = i_addr;
		tbl_we = 1'b0;
		tbl_waddr = i_addr;
		tbl_wflags = '0;
		tbl_wl2r = '0;
		tbl_wr2l = '0;
		tbl_re = 1'b0;
		tbl_raddr = i_addr;
		case (state_q)
			mvp_pkg::ST_CLEAR: begin
				tbl_we = 1'b1;
				tbl_waddr = clr_q;
			end
			mvp_pkg::ST_IDLE: begin
				pos_we = cmd_acc && cmd.action == mvp_pkg::ACT_WRITE && in_range;
				tbl_re = cmd_acc && cmd.action == mvp_pkg::ACT_READ && in_range;
				tbl_raddr = vidx_addr;
			end
			mvp_pkg::ST_I_RD: begin
				pos_re = 1'b1;
				tbl_re = 1'b1;
			end
			mvp_pkg::ST_I_CHK: begin
				// vertex i was never touched, so its entry is written whole
				tbl_we = !tbl_rflags.visited && is_mid_c;
				tbl_wflags.visited = 1'b1;
				tbl_wflags.mid = 1'b1;
			end
			mvp_pkg::ST_SCAN: begin
				pos_re = 1'b1;
				pos_raddr = j_q;
			end
			mvp_pkg::ST_WR_I: begin
				tbl_we = 1'b1;
				tbl_wflags.visited = 1'b1;
				tbl_wflags.l2r_valid = found_q && xi_neg;
				tbl_wflags.r2l_valid = found_q && !xi_neg;
				tbl_wl2r = (found_q && xi_neg) ? best_j_q : '0;
				tbl_wr2l = (found_q && !xi_neg) ? best_j_q : '0;
			end
			mvp_pkg::ST_J_RD: begin
				tbl_re = 1'b1;
				tbl_raddr = best_j_q;
			end
			mvp_pkg::ST_J_WR: begin
				// partner entry: read, modify, write back
				tbl_we = 1'b1;
				tbl_waddr = best_j_q;
				tbl_wflags = tbl_rflags;
				tbl_wflags.visited = 1'b1;
				tbl_wl2r = tbl_rl2r;
				tbl_wr2l = tbl_rr2l;
				if (xi_neg) begin
					tbl_wflags.r2l_valid = 1'b1;
					tbl_wr2l = i_addr;
				end else begin
					tbl_wflags.l2r_valid = 1'b1;
					tbl_wl2r = i_addr;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvp_pkg::ST_CLEAR;
			mid_thr_q <= mvp_pkg::THR_W'(1);
			vcnt_q <= mvp_pkg::VCNT_W'(1);
			clr_q <= '0;
			run_pend_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			drain_q <= '0;
			rd_v_q <= 1'b0;
			found_q <= 1'b0;
			cnt_mid_q <= '0;
			cnt_l2r_q <= '0;
			cnt_r2l_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_q <= (state_q == mvp_pkg::ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mvp_pkg::CFG_MID_THRESHOLD: mid_thr_q <= cfg_data[mvp_pkg::THR_W-1:0];
					mvp_pkg::CFG_VERTEX_COUNT:  vcnt_q <= cfg_data[mvp_pkg::VCNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				mvp_pkg::ST_CLEAR: clr_q <= clr_q + IW'(1);
				mvp_pkg::ST_IDLE: begin
					if (cmd_acc && cmd.action == mvp_pkg::ACT_RUN) begin
						clr_q <= '0;
						run_pend_q <= 1'b1;
						i_q <= '0;
						cnt_mid_q <= '0;
						cnt_l2r_q <= '0;
						cnt_r2l_q <= '0;
						// counts above the store size saturate
						n_q <= (int'(vcnt_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcnt_q);
					end
				end
				mvp_pkg::ST_READ: rsp_valid_q <= 1'b1;
				mvp_pkg::ST_I_CHK: begin
					j_q <= '0;
					found_q <= 1'b0;
					if (tbl_rflags.visited) begin
						i_q <= i_q + NW'(1);
					end else if (is_mid_c) begin
						i_q <= i_q + NW'(1);
						cnt_mid_q <= cnt_mid_q + NW'(1);
					end
				end
				mvp_pkg::ST_SCAN: begin
					drain_q <= '0;
					if (!j_last) begin
						j_q <= j_q + IW'(1);
					end
				end
				mvp_pkg::ST_DRAIN: drain_q <= drain_q + LW'(1);
				mvp_pkg::ST_WR_I: begin
					if (!found_q) begin
						i_q <= i_q + NW'(1);
					end else if (xi_neg) begin
						cnt_l2r_q <= cnt_l2r_q + NW'(1);
					end else begin
						cnt_r2l_q <= cnt_r2l_q + NW'(1);
					end
				end
				mvp_pkg::ST_J_WR: begin
					i_q <= i_q + NW'(1);
					if (xi_neg && !tbl_rflags.r2l_valid) begin
						cnt_r2l_q <= cnt_r2l_q + NW'(1);
					end
					if (!xi_neg && !tbl_rflags.l2r_valid) begin
						cnt_l2r_q <= cnt_l2r_q + NW'(1);
					end
				end
				mvp_pkg::ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						run_pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		jr_q <= j_q;
		if (take) begin
			best_q <= dist_sq;
			best_j_q <= dist_j;
		end
		if (state_q == mvp_pkg::ST_IDLE && cmd_acc) begin
			rd_ok_q <= in_range;
		end
		if (state_q == mvp_pkg::ST_I_CHK) begin
			xi_q <= pos_rx;
			yi_q <= pos_ry;
			zi_q <= pos_rz;
		end
		if (state_q == mvp_pkg::ST_READ) begin
			rsp_q.is_mid <= rd_ok_q && tbl_rflags.mid;
			rsp_q.right_partner_valid <= rd_ok_q && tbl_rflags.l2r_valid;
			rsp_q.right_partner <= (rd_ok_q && tbl_rflags.l2r_valid) ?
				mvp_pkg::VIDX_W'(tbl_rl2r) : '0;
			rsp_q.left_partner_valid <= rd_ok_q && tbl_rflags.r2l_valid;
			rsp_q.left_partner <= (rd_ok_q && tbl_rflags.r2l_valid) ?
				mvp_pkg::VIDX_W'(tbl_rr2l) : '0;
			rsp_q.mid_count <= mvp_pkg::CNT_W'(cnt_mid_q);
			rsp_q.left_count <= mvp_pkg::CNT_W'(cnt_l2r_q);
			rsp_q.right_count <= mvp_pkg::CNT_W'(cnt_r2l_q);
		end else if (state_q == mvp_pkg::ST_DONE && rsp_free) begin
			rsp_q.is_mid <= 1'b0;
			rsp_q.right_partner_valid <= 1'b0;
			rsp_q.right_partner <= '0;
			rsp_q.left_partner_valid <= 1'b0;
			rsp_q.left_partner <= '0;
			rsp_q.mid_count <= mvp_pkg::CNT_W'(cnt_mid_q);
			rsp_q.left_count <= mvp_pkg::CNT_W'(cnt_l2r_q);
			rsp_q.right_count <= mvp_pkg::CNT_W'(cnt_r2l_q);
		end
	end

`ifndef ASSERT_OFF
	// candidate index stays inside the run
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvp_pkg::ST_SCAN |-> NW'(j_q) < n_q)
		else $error("scan index beyond vertex count");

	// all candidates compared before the table update
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvp_pkg::ST_WR_I |-> !dist_v && !rd_v_q)
		else $error("distance pipeline not empty at table update");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvp_pkg::ST_J_RD |-> found_q && NW'(best_j_q) < n_q)
		else $error("partner index out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_mid_q <= n_q && cnt_l2r_q <= n_q && cnt_r2l_q <= n_q)
		else $error("run count exceeds vertex count");

	// a run finishes only after every vertex was visited
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvp_pkg::ST_DONE |-> i_q == n_q && run_pend_q)
		else $error("run finished early");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mvp_pos_store.sv =====
`default_nettype none
module mvp_pos_store #(
	parameter int DEPTH = mvp_pkg::MAX_VERTICES_DEF,
	parameter int CW = mvp_pkg::COORD_WIDTH_DEF,
	parameter int IW = $clog2(mvp_pkg::MAX_VERTICES_DEF)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IW-1:0]        waddr,
	input  wire logic signed [CW-1:0] wx,
	input  wire logic signed [CW-1:0] wy,
	input  wire logic signed [CW-1:0] wz,
	input  wire logic                 re,
	input  wire logic [IW-1:0]        raddr,
	output logic signed [CW-1:0]      rx,
	output logic signed [CW-1:0]      ry,
	output logic signed [CW-1:0]      rz
);

	logic [3*CW-1:0] mem [DEPTH];
	logic [3*CW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy, wz};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rx = $signed(rd_q[3*CW-1:2*CW]);
	assign ry = $signed(rd_q[2*CW-1:CW]);
	assign rz = $signed(rd_q[CW-1:0]);

endmodule
`default_nettype wire

// ===== rtl/core/mvp_tbl_store.sv =====
`default_nettype none
module mvp_tbl_store #(
	parameter int DEPTH = mvp_pkg::MAX_VERTICES_DEF,
	parameter int IW = $clog2(mvp_pkg::MAX_VERTICES_DEF)
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [IW-1:0]         waddr,
	input  wire mvp_pkg::tbl_flags_t   wflags,
	input  wire logic [IW-1:0]         wl2r,
	input  wire logic [IW-1:0]         wr2l,
	input  wire logic                  re,
	input  wire logic [IW-1:0]         raddr,
	output mvp_pkg::tbl_flags_t        rflags,
	output logic [IW-1:0]              rl2r,
	output logic [IW-1:0]              rr2l
);

	localparam int EW = $bits(mvp_pkg::tbl_flags_t) + 2 * IW;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wflags, wl2r, wr2l};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rflags = mvp_pkg::tbl_flags_t'(rd_q[EW-1:2*IW]);
	assign rl2r = rd_q[2*IW-1:IW];
	assign rr2l = rd_q[IW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/mvp_dist_pipe.sv =====
`default_nettype none
module mvp_dist_pipe #(
	parameter int CW = mvp_pkg::COORD_WIDTH_DEF,
	parameter int IW = $clog2(mvp_pkg::MAX_VERTICES_DEF)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [CW-1:0]    xi,
	input  wire logic signed [CW-1:0]    yi,
	input  wire logic signed [CW-1:0]    zi,
	input  wire logic signed [CW-1:0]    xj,
	input  wire logic signed [CW-1:0]    yj,
	input  wire logic signed [CW-1:0]    zj,
	input  wire logic [IW-1:0]           j_in,
	output logic                         out_valid,
	output logic                         opposite,
	output logic [2*(CW+1)+1:0]          dist_sq,
	output logic [IW-1:0]                j_out
);

	localparam int DW = CW + 1;
	localparam int SQ = 2 * DW;
	localparam int SW = SQ + 2;

	logic signed [DW-1:0] sx, sy, sz;
	logic [DW-1:0] ax, ay, az;
	logic opp_c;

	logic v_s1, v_s2, v_s3;
	logic [DW-1:0] ax_s1, ay_s1, az_s1;
	logic opp_s1, opp_s2, opp_s3;
	logic [IW-1:0] j_s1, j_s2, j_s3;
	logic [SQ-1:0] qx_s2, qy_s2, qz_s2;
	logic [SW-1:0] sum_s3;

	// x is mirrored, so its difference is a sum
	always_comb begin
		sx = DW'(xi) + DW'(xj);
		sy = DW'(yi) - DW'(yj);
		sz = DW'(zi) - DW'(zj);
		ax = sx[DW-1] ? DW'(-sx) : DW'(sx);
		ay = sy[DW-1] ? DW'(-sy) : DW'(sy);
		az = sz[DW-1] ? DW'(-sz) : DW'(sz);
		opp_c = (xi <= 0 && xj >= 0) || (xi >= 0 && xj <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		az_s1 <= az;
		opp_s1 <= opp_c;
		j_s1 <= j_in;
		qx_s2 <= SQ'(ax_s1) * SQ'(ax_s1);
		qy_s2 <= SQ'(ay_s1) * SQ'(ay_s1);
		qz_s2 <= SQ'(az_s1) * SQ'(az_s1);
		opp_s2 <= opp_s1;
		j_s2 <= j_s1;
		sum_s3 <= SW'(qx_s2) + SW'(qy_s2) + SW'(qz_s2);
		opp_s3 <= opp_s2;
		j_s3 <= j_s2;
	end

	assign out_valid = v_s3;
	assign opposite = opp_s3;
	assign dist_sq = sum_s3;
	assign j_out = j_s3;

endmodule
`default_nettype wire
